/* src/quaternion_vector_rotate_macros.svh */
// Assertion helpers shared by the rotator RTL.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef QUATERNION_VECTOR_ROTATE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_MACROS_SVH

// Same-cycle implication
`define QVR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/qvr_pkg.sv */
`timescale 1ns / 1ps
package qvr_pkg;

  // Field widths
  localparam int VEC_WIDTH      = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int QUAT_W         = 16;
  localparam int OUT_W          = 18;
  localparam int CFG_IDX_W      = 2;

  // Datapath widths
  localparam int PROD_W  = 2 * QUAT_W;
  localparam int COEF_W  = PROD_W + 2;
  localparam int MUL_W   = COEF_W + VEC_WIDTH;
  localparam int SUM_W   = MUL_W + 2;
  localparam int SHIFT   = 2 * QUAT_FRAC_BITS;
  localparam int SH_W    = SUM_W - SHIFT;

  // Pipeline depth: input, products, coefficients, multiply, sum, saturate
  localparam int NSTG = 6;

  localparam logic signed [QUAT_W-1:0] QUAT_W_RESET = QUAT_W'(1 << QUAT_FRAC_BITS);
  localparam logic signed [SUM_W-1:0]  ROUND_HALF   = SUM_W'(1) <<< (SHIFT - 1);

  typedef logic signed [QUAT_W-1:0]    quat_t;
  typedef logic signed [VEC_WIDTH-1:0] vec_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [MUL_W-1:0]     mul_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [SH_W-1:0]      sh_t;
  typedef logic signed [OUT_W-1:0]     rot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } qvr_reg_t;

  // One row of the rotation matrix
  typedef struct packed {
    coef_t c0;
    coef_t c1;
    coef_t c2;
  } qvr_row_t;

  // Stage enables for the coefficient unit
  typedef struct packed {
    logic en_prod;
    logic en_coef;
  } qvr_coef_ctl_t;

  // Stage enables for one output lane
  typedef struct packed {
    logic en_mul;
    logic en_sum;
    logic en_sat;
  } qvr_dot_ctl_t;

  // Sign-extend a quaternion product to coefficient width
  function automatic coef_t sx_prod(input prod_t p);
    sx_prod = {{(COEF_W - PROD_W){p[PROD_W-1]}}, p};
  endfunction

  // Sign-extend a lane product to sum width
  function automatic sum_t sx_mul(input mul_t m);
    sx_mul = {{(SUM_W - MUL_W){m[MUL_W-1]}}, m};
  endfunction

endpackage

/* src/qvr_coef.sv */
`timescale 1ns / 1ps
module qvr_coef
  import qvr_pkg::*;
(
  input  logic          clk,
  input  qvr_coef_ctl_t ctl,
  input  quat_t         quat_x,
  input  quat_t         quat_y,
  input  quat_t         quat_z,
  input  quat_t         quat_w,
  output qvr_row_t      row_x,
  output qvr_row_t      row_y,
  output qvr_row_t      row_z
);

  prod_t xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  coef_t xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
  qvr_row_t row_x_r, row_y_r, row_z_r;
  qvr_row_t row_x_nxt, row_y_nxt, row_z_nxt;

  // Form all ten pairwise products of the quaternion
  always_ff @(posedge clk) begin
    if (ctl.en_prod) begin
      xx_r <= quat_x * quat_x;
      yy_r <= quat_y * quat_y;
      zz_r <= quat_z * quat_z;
      ww_r <= quat_w * quat_w;
      xy_r <= quat_x * quat_y;
      xz_r <= quat_x * quat_z;
      yz_r <= quat_y * quat_z;
      wx_r <= quat_w * quat_x;
      wy_r <= quat_w * quat_y;
      wz_r <= quat_w * quat_z;
    end
  end

  // Combine products into the rotation matrix
  always_comb begin
    xx = sx_prod(xx_r);
    yy = sx_prod(yy_r);
    zz = sx_prod(zz_r);
    ww = sx_prod(ww_r);
    xy = sx_prod(xy_r);
    xz = sx_prod(xz_r);
    yz = sx_prod(yz_r);
    wx = sx_prod(wx_r);
    wy = sx_prod(wy_r);
    wz = sx_prod(wz_r);
    row_x_nxt.c0 = ww + xx - yy - zz;
    row_x_nxt.c1 = (xy - wz) <<< 1;
    row_x_nxt.c2 = (xz + wy) <<< 1;
    row_y_nxt.c0 = (xy + wz) <<< 1;
    row_y_nxt.c1 = ww - xx + yy - zz;
    row_y_nxt.c2 = (yz - wx) <<< 1;
    row_z_nxt.c0 = (xz - wy) <<< 1;
    row_z_nxt.c1 = (yz + wx) <<< 1;
    row_z_nxt.c2 = ww - xx - yy + zz;
  end

  always_ff @(posedge clk) begin
    if (ctl.en_coef) begin
      row_x_r <= row_x_nxt;
      row_y_r <= row_y_nxt;
      row_z_r <= row_z_nxt;
    end
  end

  assign row_x = row_x_r;
  assign row_y = row_y_r;
  assign row_z = row_z_r;

endmodule

/* src/qvr_dot.sv */
`timescale 1ns / 1ps
module qvr_dot
  import qvr_pkg::*;
(
  input  logic         clk,
  input  qvr_dot_ctl_t ctl,
  input  qvr_row_t     row,
  input  vec_t         v0,
  input  vec_t         v1,
  input  vec_t         v2,
  output rot_t         rot,
  output logic         ovf
);

  mul_t m0_r, m1_r, m2_r;
  sum_t sum_nxt;
  sh_t  sh_r;
  rot_t rot_r, rot_nxt;
  logic ovf_r, ovf_nxt;
  logic all_one, all_zero;

  // Multiply each coefficient by its vector component
  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      m0_r <= MUL_W'(row.c0) * MUL_W'(v0);
      m1_r <= MUL_W'(row.c1) * MUL_W'(v1);
      m2_r <= MUL_W'(row.c2) * MUL_W'(v2);
    end
  end

  // Add, round half up, and drop the fraction bits
  assign sum_nxt = sx_mul(m0_r) + sx_mul(m1_r) + sx_mul(m2_r) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (ctl.en_sum) begin
      sh_r <= sh_t'(sum_nxt[SUM_W-1:SHIFT]);
    end
  end

  // Clamp to the output range when the top bits disagree with the sign
  always_comb begin
    all_one  = &sh_r[SH_W-1:OUT_W-1];
    all_zero = ~|sh_r[SH_W-1:OUT_W-1];
    ovf_nxt  = !(all_one || all_zero);
    if (!ovf_nxt) begin
      rot_nxt = sh_r[OUT_W-1:0];
    end else if (sh_r[SH_W-1]) begin
      rot_nxt = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      rot_nxt = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_sat) begin
      rot_r <= rot_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign rot = rot_r;
  assign ovf = ovf_r;

endmodule

/* src/quaternion_vector_rotate.sv */
// A word accepted into the input stage appears on out_valid once it reaches the saturate stage.
// Throughput: one word per cycle while out_stall is low; six register stages
// (input, quaternion products, matrix coefficients, multiply, sum/round, saturate).
// A stall holds every occupied stage whose successor cannot take its word.
// Reset (synchronous, rst_n low) empties the pipeline and sets the quaternion
// to identity: x = y = z = 0, w = 1.0.
`timescale 1ns / 1ps
module quaternion_vector_rotate
  import qvr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QUAT_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vec_t                 in_vec_x,
  input  vec_t                 in_vec_y,
  input  vec_t                 in_vec_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rot_t                 out_rot_x,
  output rot_t                 out_rot_y,
  output rot_t                 out_rot_z,
  output logic                 out_overflow
);

  quat_t quat_x_r, quat_y_r, quat_z_r, quat_w_r;
  logic [NSTG-1:0] v_r, v_nxt, mv;
  logic accept;
  vec_t vec1_r [3];
  vec_t vec2_r [3];
  vec_t vec3_r [3];
  qvr_row_t row_x, row_y, row_z;
  qvr_coef_ctl_t coef_ctl;
  qvr_dot_ctl_t dot_ctl;
  logic ovf_x, ovf_y, ovf_z;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_x_r <= '0;
      quat_y_r <= '0;
      quat_z_r <= '0;
      quat_w_r <= QUAT_W_RESET;
    end else if (cfg_wr_en) begin
      case (qvr_reg_t'(cfg_index))
        REG_QUAT_X: quat_x_r <= cfg_wdata;
        REG_QUAT_Y: quat_y_r <= cfg_wdata;
        REG_QUAT_Z: quat_z_r <= cfg_wdata;
        REG_QUAT_W: quat_w_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    mv[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      mv[k] = !v_r[k] || mv[k+1];
    end
  end

  assign in_stall = !mv[0];
  assign accept   = in_valid && mv[0];

  always_comb begin
    v_nxt = v_r;
    if (mv[0]) begin
      v_nxt[0] = accept;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (mv[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Carry the vector alongside the coefficient stages
  always_ff @(posedge clk) begin
    if (mv[0]) begin
      vec1_r[0] <= in_vec_x;
      vec1_r[1] <= in_vec_y;
      vec1_r[2] <= in_vec_z;
    end
    if (mv[1]) begin
      vec2_r <= vec1_r;
    end
    if (mv[2]) begin
      vec3_r <= vec2_r;
    end
  end

  assign coef_ctl.en_prod = mv[1];
  assign coef_ctl.en_coef = mv[2];
  assign dot_ctl.en_mul   = mv[3];
  assign dot_ctl.en_sum   = mv[4];
  assign dot_ctl.en_sat   = mv[5];

  qvr_coef u_coef (
    .clk    (clk),
    .ctl    (coef_ctl),
    .quat_x (quat_x_r),
    .quat_y (quat_y_r),
    .quat_z (quat_z_r),
    .quat_w (quat_w_r),
    .row_x  (row_x),
    .row_y  (row_y),
    .row_z  (row_z)
  );

  qvr_dot u_dot_x (
    .clk (clk),
    .ctl (dot_ctl),
    .row (row_x),
    .v0  (vec3_r[0]),
    .v1  (vec3_r[1]),
    .v2  (vec3_r[2]),
    .rot (out_rot_x),
    .ovf (ovf_x)
  );

  qvr_dot u_dot_y (
    .clk (clk),
    .ctl (dot_ctl),
    .row (row_y),
    .v0  (vec3_r[0]),
    .v1  (vec3_r[1]),
    .v2  (vec3_r[2]),
    .rot (out_rot_y),
    .ovf (ovf_y)
  );

  qvr_dot u_dot_z (
    .clk (clk),
    .ctl (dot_ctl),
    .row (row_z),
    .v0  (vec3_r[0]),
    .v1  (vec3_r[1]),
    .v2  (vec3_r[2]),
    .rot (out_rot_z),
    .ovf (ovf_z)
  );

  assign out_valid    = v_r[NSTG-1];
  assign out_overflow = ovf_x || ovf_y || ovf_z;

`include "quaternion_vector_rotate_macros.svh"

  `QVR_ASSERT_NOW(a_empty_out_no_stall, !out_valid, !in_stall, "stall with empty output stage")
  `QVR_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, v_r[0], "accepted word lost at entry")
  `QVR_ASSERT_NEXT(a_mid_hold, v_r[2] && !mv[3], v_r[2], "stalled stage dropped its word")
  `QVR_ASSERT_NOW(a_ovf_clamped, out_valid && out_overflow, (out_rot_x == {1'b1, {(OUT_W-1){1'b0}}}) || (out_rot_x == {1'b0, {(OUT_W-1){1'b1}}}) || (out_rot_y == {1'b1, {(OUT_W-1){1'b0}}}) || (out_rot_y == {1'b0, {(OUT_W-1){1'b1}}}) || (out_rot_z == {1'b1, {(OUT_W-1){1'b0}}}) || (out_rot_z == {1'b0, {(OUT_W-1){1'b1}}}), "overflow flag without a clamped lane")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import qvr_pkg::*;

  // One rotated word as it leaves the block
  typedef struct packed {
    rot_t x;
    rot_t y;
    rot_t z;
    logic ovf;
  } rot_word_t;

  // One directed row: quaternion, vector, and optionally a hand-typed result
  typedef struct packed {
    quat_t     qx;
    quat_t     qy;
    quat_t     qz;
    quat_t     qw;
    vec_t      vx;
    vec_t      vy;
    vec_t      vz;
    logic      typed;
    rot_word_t rot;
  } vec_case_t;

  localparam int      NUM_DIR    = 20;
  localparam int      NUM_PHASES = 7;
  localparam int      PHASE_LEN  = 100;
  localparam longint  ROT_MAX    = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint  ROT_MIN    = -(longint'(1) <<< (OUT_W - 1));
  localparam longint  HALF_LSB   = longint'(1) <<< (SHIFT - 1);

  localparam vec_case_t DIR_CASES [NUM_DIR] = '{
    // identity right after reset, no register write
    '{0, 0, 0, 16384, 1, 2, 3, 1, '{1, 2, 3, 0}},
    '{0, 0, 0, 16384, 32767, -32768, 0, 1, '{32767, -32768, 0, 0}},
    '{0, 0, 0, 16384, -1, -1, -1, 1, '{-1, -1, -1, 0}},
    // w = -2.0 scales by four, lands exactly on the negative limit
    '{0, 0, 0, -32768, 32767, -32768, 1, 1, '{131068, -131072, 4, 0}},
    '{0, 0, 0, -32768, -32768, -32768, -32768, 1, '{-131072, -131072, -131072, 0}},
    // all components at the negative extreme: permute and scale by 16, saturating
    '{-32768, -32768, -32768, -32768, 32767, -32768, 8191, 1, '{131056, 131071, -131072, 1}},
    '{-32768, -32768, -32768, -32768, 1, -1, 0, 1, '{0, 16, -16, 0}},
    // all components at the positive extreme
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, '{0, 0, 0, 0}},
    '{32767, 32767, 32767, 32767, -32768, 0, -1, 0, '{0, 0, 0, 0}},
    // w = 0.5 scales by a quarter: rounding of halves and quarters
    '{0, 0, 0, 8192, 2, -2, 6, 1, '{1, 0, 2, 0}},
    '{0, 0, 0, 8192, 1, -1, -6, 1, '{0, 0, -1, 0}},
    // zero quaternion wipes every vector
    '{0, 0, 0, 0, 32767, -32768, 32767, 1, '{0, 0, 0, 0}},
    // half turns about each axis
    '{16384, 0, 0, 0, -32768, -32768, 32767, 1, '{-32768, 32768, -32767, 0}},
    '{0, 16384, 0, 0, 5, 6, 7, 1, '{-5, 6, -7, 0}},
    '{0, 0, 16384, 0, 5, 6, 7, 1, '{-5, -6, 7, 0}},
    // quarter turn about z
    '{0, 0, 11585, 11585, 16384, 0, 0, 0, '{0, 0, 0, 0}},
    '{0, 0, 11585, 11585, 0, -32768, 100, 0, '{0, 0, 0, 0}},
    // arbitrary non-unit quaternion
    '{12345, -23456, 30000, -1, 32767, -32768, -1, 0, '{0, 0, 0, 0}},
    '{12345, -23456, 30000, -1, 0, 0, 0, 1, '{0, 0, 0, 0}},
    '{-32768, 32767, -32768, 32767, -32768, -32768, -32768, 0, '{0, 0, 0, 0}}
  };

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 cfg_wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [QUAT_W-1:0]    cfg_wdata    = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  vec_t                 in_vec_x     = '0;
  vec_t                 in_vec_y     = '0;
  vec_t                 in_vec_z     = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  rot_t                 out_rot_x;
  rot_t                 out_rot_y;
  rot_t                 out_rot_z;
  logic                 out_overflow;

  // Quaternion as the block currently holds it
  quat_t quat_x_q = '0;
  quat_t quat_y_q = '0;
  quat_t quat_z_q = '0;
  quat_t quat_w_q = quat_t'(16384);

  rot_word_t rot_pending [$];
  int        n_fail    = 0;
  int        burst_left = 0;

  quaternion_vector_rotate i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_vec_z     (in_vec_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rot_x    (out_rot_x),
    .out_rot_y    (out_rot_y),
    .out_rot_z    (out_rot_z),
    .out_overflow (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rotate v by the held quaternion: exact matrix product, round half up, saturate
  function automatic rot_word_t rotate_vec(input vec_t vx, input vec_t vy, input vec_t vz);
    longint    x, y, z, w, acc;
    longint    coef [3][3];
    longint    v [3];
    rot_t      comp [3];
    logic      sat;
    rot_word_t res;
    x = quat_x_q;
    y = quat_y_q;
    z = quat_z_q;
    w = quat_w_q;
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    coef[0][0] = w * w + x * x - y * y - z * z;
    coef[0][1] = 2 * (x * y - w * z);
    coef[0][2] = 2 * (x * z + w * y);
    coef[1][0] = 2 * (x * y + w * z);
    coef[1][1] = w * w - x * x + y * y - z * z;
    coef[1][2] = 2 * (y * z - w * x);
    coef[2][0] = 2 * (x * z - w * y);
    coef[2][1] = 2 * (y * z + w * x);
    coef[2][2] = w * w - x * x - y * y + z * z;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = coef[i][0] * v[0] + coef[i][1] * v[1] + coef[i][2] * v[2];
      acc = (acc + HALF_LSB) >>> SHIFT;
      if (acc > ROT_MAX) begin
        acc = ROT_MAX;
        sat = 1'b1;
      end else if (acc < ROT_MIN) begin
        acc = ROT_MIN;
        sat = 1'b1;
      end
      comp[i] = rot_t'(acc);
    end
    res.x   = comp[0];
    res.y   = comp[1];
    res.z   = comp[2];
    res.ovf = sat;
    return res;
  endfunction

  function automatic quat_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return quat_t'(16'h8000);
      1:       return quat_t'(16'h7FFF);
      2:       return quat_t'(16'hC000);
      3:       return quat_t'(16'h4000);
      default: return quat_t'(16'h0000);
    endcase
  endfunction

  // Drain the pipeline, then write all four quaternion registers
  task automatic load_quat(input quat_t qx, input quat_t qy, input quat_t qz, input quat_t qw);
    in_valid <= 1'b0;
    while (rot_pending.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_QUAT_X;
    cfg_wdata <= qx;
    @(posedge clk);
    cfg_index <= REG_QUAT_Y;
    cfg_wdata <= qy;
    @(posedge clk);
    cfg_index <= REG_QUAT_Z;
    cfg_wdata <= qz;
    @(posedge clk);
    cfg_index <= REG_QUAT_W;
    cfg_wdata <= qw;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    quat_x_q = qx;
    quat_y_q = qy;
    quat_z_q = qz;
    quat_w_q = qw;
  endtask

  // Offer one vector word in bursts with random gaps; record its result once taken
  task automatic send_vec(input vec_t vx, input vec_t vy, input vec_t vz,
                          input logic typed, input rot_word_t typed_rot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_vec_x <= vx;
    in_vec_y <= vy;
    in_vec_z <= vz;
    do @(posedge clk); while (in_stall);
    rot_pending.push_back(typed ? typed_rot : rotate_vec(vx, vy, vz));
  endtask

  // Receiver stall: switch between free, light, half and heavy stall stretches
  always @(posedge clk) begin : stall_gen
    int stall_left;
    int stall_mode;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      stall_mode = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(8, 64);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Compare each taken result word with the oldest expectation
  always @(posedge clk) begin : check_rot
    rot_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rot_pending.size() == 0) begin
        $error("result word with no expectation: x=%0d y=%0d z=%0d ovf=%0b",
               out_rot_x, out_rot_y, out_rot_z, out_overflow);
        n_fail++;
      end else begin
        want = rot_pending.pop_front();
        if (out_rot_x !== want.x) begin
          $error("rot_x: expected %0d, got %0d", want.x, out_rot_x);
          n_fail++;
        end
        if (out_rot_y !== want.y) begin
          $error("rot_y: expected %0d, got %0d", want.y, out_rot_y);
          n_fail++;
        end
        if (out_rot_z !== want.z) begin
          $error("rot_z: expected %0d, got %0d", want.z, out_rot_z);
          n_fail++;
        end
        if (out_overflow !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, out_overflow);
          n_fail++;
        end
      end
    end
  end

  // Stimulus: directed table, then random phases each with its own quaternion
  initial begin : stimulus
    quat_t     qx, qy, qz, qw;
    vec_t      vx, vy, vz;
    rot_word_t no_rot;
    no_rot = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_CASES[i]) begin
      if ({DIR_CASES[i].qx, DIR_CASES[i].qy, DIR_CASES[i].qz, DIR_CASES[i].qw} !==
          {quat_x_q, quat_y_q, quat_z_q, quat_w_q})
        load_quat(DIR_CASES[i].qx, DIR_CASES[i].qy, DIR_CASES[i].qz, DIR_CASES[i].qw);
      send_vec(DIR_CASES[i].vx, DIR_CASES[i].vy, DIR_CASES[i].vz,
               DIR_CASES[i].typed, DIR_CASES[i].rot);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // full range, components within -0.5 to 0.5, or extremes only
      case (p % 3)
        0: begin
          qx = quat_t'($urandom);
          qy = quat_t'($urandom);
          qz = quat_t'($urandom);
          qw = quat_t'($urandom);
        end
        1: begin
          qx = quat_t'($urandom_range(0, 16384) - 8192);
          qy = quat_t'($urandom_range(0, 16384) - 8192);
          qz = quat_t'($urandom_range(0, 16384) - 8192);
          qw = quat_t'($urandom_range(0, 16384) - 8192);
        end
        default: begin
          qx = pick_extreme();
          qy = pick_extreme();
          qz = pick_extreme();
          qw = pick_extreme();
        end
      endcase
      load_quat(qx, qy, qz, qw);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          vx = pick_extreme();
          vy = pick_extreme();
          vz = pick_extreme();
        end else begin
          vx = vec_t'($urandom);
          vy = vec_t'($urandom);
          vz = vec_t'($urandom);
        end
        send_vec(vx, vy, vz, 1'b0, no_rot);
      end
    end

    // Wait out the pipeline, then a little longer for stray words
    in_valid <= 1'b0;
    while (rot_pending.size() != 0) @(posedge clk);
    repeat (4 * NSTG) @(posedge clk);
    if (n_fail == 0 && rot_pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/qvr_pkg.sv
src/qvr_coef.sv
src/qvr_dot.sv
src/quaternion_vector_rotate.sv
tb/tb.sv
